// ===== design/scan_grid_triangulator_core_defines.svh =====
// Assertion macros for the scan grid triangulator core.
// No dependencies; include with the bare file name.
`ifndef SCAN_GRID_TRIANGULATOR_CORE_DEFINES_SVH
`define SCAN_GRID_TRIANGULATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SGT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SGT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sgt_pkg.sv =====
// Shared types and constants for the scan grid triangulator.
// No dependencies.
package sgt_pkg;

  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd10;
  localparam int CFG_MIN = 2;

  typedef enum logic [1:0] {
    ROW_FIRST,
    ROW_MID,
    ROW_LAST
  } row_kind_t;

  // Control of the point waiting for its triangles.
  typedef struct packed {
    logic      seen;
    row_kind_t kind;
    logic      phase;
  } emit_ctl_t;

endpackage

// ===== design/scan_grid_triangulator_core.sv =====
// Scan grid triangulator core. Points arrive column by column, with
// points_per_column rows in each column (values below 2 act as 2, above
// MAX_COLUMN_POINTS as MAX_COLUMN_POINTS). The first column of a scan gives
// no triangles; each later point gives one triangle on the first and last
// row and two on every other row, the final one flagged by last_of_run.
// new_scan restarts the row count and the column history. Timing: a point
// is written to the delay line and its two previous-column neighbors are
// read in the cycle it is accepted; its triangles then pass from the emit
// stage to the single triangle output register, one per cycle unless
// out_stall holds it. A middle-row point stays in the emit stage until
// both its triangles have left; a new point is taken once the stage is
// empty or its point finishes. The delay line needs no clearing pass
// after reset. Write points_per_column only while idle.
`include "scan_grid_triangulator_core_defines.svh"

module scan_grid_triangulator_core #(
  parameter int MAX_COLUMN_POINTS = 16,
  parameter int COORD_WIDTH       = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_wen,
  input  logic [sgt_pkg::CFG_W-1:0]     cfg_wdata,
  // point channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          new_scan,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  // triangle channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] a_x,
  output logic signed [COORD_WIDTH-1:0] a_y,
  output logic signed [COORD_WIDTH-1:0] a_z,
  output logic signed [COORD_WIDTH-1:0] b_x,
  output logic signed [COORD_WIDTH-1:0] b_y,
  output logic signed [COORD_WIDTH-1:0] b_z,
  output logic signed [COORD_WIDTH-1:0] c_x,
  output logic signed [COORD_WIDTH-1:0] c_y,
  output logic signed [COORD_WIDTH-1:0] c_z,
  output logic                          last_of_run
);

  import sgt_pkg::*;

  localparam int ADDR_W = $clog2(MAX_COLUMN_POINTS);
  localparam int CNT_W  = $clog2(MAX_COLUMN_POINTS + 1);
  localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int PT_W   = 3 * COORD_WIDTH;
  localparam logic [CMP_W-1:0] N_MAX = CMP_W'(MAX_COLUMN_POINTS);
  localparam logic [CMP_W-1:0] N_MIN = CMP_W'(CFG_MIN);

  // ---------------------------------------------------------------------
  // Configuration and row tracking
  // ---------------------------------------------------------------------
  logic [CFG_W-1:0]  points_per_column;
  logic [ADDR_W-1:0] row_position;
  logic              col_seen;

  logic [CMP_W-1:0]  cfg_ext;
  logic [CMP_W-1:0]  n_eff;
  logic [ADDR_W-1:0] row_cur;
  logic [CMP_W-1:0]  row_cur_ext;
  logic [ADDR_W-1:0] row_after;
  logic              row_is_last;
  logic              seen_in;
  row_kind_t         kind_in;
  logic              in_take;
  logic [PT_W-1:0]   cur_pt;

  always_comb begin
    cfg_ext = CMP_W'(points_per_column);
    priority if (cfg_ext < N_MIN) begin
      n_eff = N_MIN;
    end else if (cfg_ext > N_MAX) begin
      n_eff = N_MAX;
    end else begin
      n_eff = cfg_ext;
    end
    // A new scan, or a column length that shrank below the row, restarts
    // the column at row zero.
    if (new_scan || (CMP_W'(row_position) >= n_eff)) begin
      row_cur = '0;
    end else begin
      row_cur = row_position;
    end
    row_cur_ext = CMP_W'(row_cur);
    row_after   = row_cur + ADDR_W'(1);
    row_is_last = (row_cur_ext == (n_eff - CMP_W'(1)));
    seen_in     = col_seen && !new_scan;
    priority if (row_cur == '0) begin
      kind_in = ROW_FIRST;
    end else if (row_is_last) begin
      kind_in = ROW_LAST;
    end else begin
      kind_in = ROW_MID;
    end
  end

  assign cur_pt  = {point_x, point_y, point_z};
  assign in_take = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      points_per_column <= CFG_RESET;
      row_position      <= '0;
      col_seen          <= 1'b0;
    end else begin
      if (cfg_wen) begin
        points_per_column <= cfg_wdata;
      end
      if (in_take) begin
        if (row_is_last) begin
          row_position <= '0;
          col_seen     <= 1'b1;
        end else begin
          row_position <= row_after;
          col_seen     <= seen_in;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Delay line: write the new point at its row and read the previous
  // column's point at this row and the next one in the same cycle. The
  // read sees the old entry, so no forwarding is needed; a later point
  // only reads rows written at least one transaction earlier.
  // ---------------------------------------------------------------------
  logic [PT_W-1:0] rd_same;
  logic [PT_W-1:0] rd_next;

  sgt_delay_line #(
    .DEPTH  (MAX_COLUMN_POINTS),
    .DATA_W (PT_W)
  ) u_delay_line (
    .clk       (clk),
    .wr_en     (in_take),
    .wr_addr   (row_cur),
    .wr_data   (cur_pt),
    .rd_en     (in_take),
    .rd_addr_a (row_cur),
    .rd_addr_b (row_after),
    .rd_data_a (rd_same),
    .rd_data_b (rd_next)
  );

  // ---------------------------------------------------------------------
  // Emit stage: hold the accepted point and its predecessor while its
  // triangles drain into the output register.
  // ---------------------------------------------------------------------
  logic            s1_valid;
  emit_ctl_t       s1_ctl;
  logic [PT_W-1:0] s1_cur;
  logic [PT_W-1:0] s1_before;

  logic            out_free;
  logic            emit_go;
  logic            more_after;
  logic            s1_done;
  logic            use_next;
  logic [PT_W-1:0] tri_b;
  logic [PT_W-1:0] tri_c;

  always_comb begin
    out_free   = !out_valid || !out_stall;
    emit_go    = s1_valid && s1_ctl.seen && out_free;
    more_after = (s1_ctl.kind == ROW_MID) && !s1_ctl.phase;
    // A first-column point leaves at once with nothing to emit.
    s1_done    = s1_valid && (!s1_ctl.seen || (out_free && !more_after));
    use_next   = (s1_ctl.kind == ROW_FIRST) || ((s1_ctl.kind == ROW_MID) && s1_ctl.phase);
    if (use_next) begin
      tri_b = s1_cur;
      tri_c = rd_next;
    end else begin
      tri_b = s1_before;
      tri_c = s1_cur;
    end
  end

  // Take a new point while the stage is empty or the held one finishes in this cycle.
  assign in_stall = s1_valid && !s1_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_ctl   <= '{seen: 1'b0, kind: ROW_FIRST, phase: 1'b0};
    end else if (in_take) begin
      s1_valid <= 1'b1;
      s1_ctl   <= '{seen: seen_in, kind: kind_in, phase: 1'b0};
    end else if (s1_done) begin
      s1_valid <= 1'b0;
    end else if (emit_go) begin
      s1_ctl.phase <= 1'b1;
    end
  end

  // Q' is always the point accepted just before, since a row above zero
  // is only reached from the row before it.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cur    <= cur_pt;
      s1_before <= s1_cur;
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      a_x         <= rd_same[PT_W-1 -: COORD_WIDTH];
      a_y         <= rd_same[2*COORD_WIDTH-1 -: COORD_WIDTH];
      a_z         <= rd_same[COORD_WIDTH-1:0];
      b_x         <= tri_b[PT_W-1 -: COORD_WIDTH];
      b_y         <= tri_b[2*COORD_WIDTH-1 -: COORD_WIDTH];
      b_z         <= tri_b[COORD_WIDTH-1:0];
      c_x         <= tri_c[PT_W-1 -: COORD_WIDTH];
      c_y         <= tri_c[2*COORD_WIDTH-1 -: COORD_WIDTH];
      c_z         <= tri_c[COORD_WIDTH-1:0];
      last_of_run <= !more_after;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `SGT_ASSERT_NEXT(a_pair_back_to_back, clk, rst,
    out_valid && !out_stall && !last_of_run, out_valid && last_of_run,
    "second triangle of a middle row did not follow the first")
  `SGT_ASSERT_NOW(a_phase_mid_only, clk, rst,
    s1_valid && s1_ctl.phase, s1_ctl.kind == ROW_MID,
    "second phase on a point that has one triangle")
  `SGT_ASSERT_NOW(a_row_in_range, clk, rst,
    in_take, row_cur_ext < n_eff,
    "delay line row beyond the column length")
  `SGT_ASSERT_NEXT(a_new_scan_silent, clk, rst,
    in_take && new_scan, s1_valid && !s1_ctl.seen,
    "first point of a scan would emit triangles")

endmodule

// ===== design/sgt_delay_line.sv =====
// Column delay line: one write port, two registered read ports.
// No dependencies.
module sgt_delay_line #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 48
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [DATA_W-1:0]        rd_data_a,
  output logic [DATA_W-1:0]        rd_data_b
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Reads return the old contents on a same-address write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule
